// File: design/asl_pkg.sv
package asl_pkg;

    // Lexer modes
    typedef enum logic [2:0] {
        MODE_BEGIN,
        MODE_COMMENT,
        MODE_BIN,
        MODE_DEC,
        MODE_HEX,
        MODE_WORD
    } mode_t;

    // Token kinds
    localparam logic [3:0] KIND_NUM     = 4'd0;
    localparam logic [3:0] KIND_OP      = 4'd1;
    localparam logic [3:0] KIND_COLON   = 4'd2;
    localparam logic [3:0] KIND_COMMA   = 4'd3;
    localparam logic [3:0] KIND_NEWLINE = 4'd4;
    localparam logic [3:0] KIND_OPEN    = 4'd5;
    localparam logic [3:0] KIND_CLOSE   = 4'd6;
    localparam logic [3:0] KIND_WORD    = 4'd7;
    localparam logic [3:0] KIND_END     = 4'd8;
    localparam logic [3:0] KIND_ERROR   = 4'd9;

    // Error kinds
    localparam logic [1:0] ERR_UNKNOWN = 2'd0;
    localparam logic [1:0] ERR_BIN     = 2'd1;
    localparam logic [1:0] ERR_DEC     = 2'd2;
    localparam logic [1:0] ERR_HEX     = 2'd3;

    // Character codes
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_VT      = 8'h0B;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_F    = 8'h46;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_F    = 8'h66;
    localparam logic [7:0] CH_LO_Z    = 8'h7A;
    localparam logic [7:0] CH_TILDE   = 8'h7E;

    // Saturation limits
    localparam logic [23:0] MAX24 = 24'hFFFFFF;
    localparam logic [15:0] MAX16 = 16'hFFFF;

    // Result queue
    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic        last;
        logic [1:0]  err;
        logic [15:0] column;
        logic [23:0] line;
        logic [15:0] length;
        logic [23:0] start;
        logic [31:0] value;
        logic [3:0]  kind;
    } token_t;

endpackage

// File: design/assembler_source_lexer.sv
// Path: an accepted transaction waits in the input register until the core takes it,
// which needs queue room; its tokens are registered in the queue, then shown on m_tvalid.
// Throughput: one character per cycle while the queue has room; the output side moves one
// token per cycle while m_tready is high, and a four-entry token queue absorbs token pairs.
// Reset: synchronous on aresetn low; clears the queue, lexer mode, halt and counters,
// with the line counter starting at one.
module assembler_source_lexer #(
    parameter int VALUE_BITS = 32,
    parameter int TAB_STOP   = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // char_code[7:0]
    input  logic [0:0]   s_tuser,   // end_of_text[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // token_value[31:0], start_index[55:32], token_length[71:56],
    // line_number[95:72], column_number[111:96]
    output logic [111:0] m_tdata,
    output logic [5:0]   m_tuser,   // token_kind[3:0], error_kind[5:4]
    output logic         m_tlast    // last_of_run
);

    logic            in_valid_reg;
    logic [7:0]      in_char_reg;
    logic            in_eot_reg;
    logic            core_take;
    logic            room;
    logic [1:0]      tok_count;
    asl_pkg::token_t tok0, tok1, out_tok;

    assign core_take = in_valid_reg && room;
    assign s_tready  = !in_valid_reg || core_take;

    // Input register: hold the transaction until the lexer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (core_take) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_eot_reg  <= s_tuser[0];
        end
    end

    asl_lexer_core #(
        .VALUE_BITS (VALUE_BITS),
        .TAB_STOP   (TAB_STOP)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_take   (core_take),
        .in_char   (in_char_reg),
        .in_eot    (in_eot_reg),
        .tok0      (tok0),
        .tok1      (tok1),
        .tok_count (tok_count)
    );

    asl_token_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_count  (tok_count),
        .wr_tok0   (tok0),
        .wr_tok1   (tok1),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (out_tok)
    );

    // Pack the result transaction
    assign m_tdata = {out_tok.column, out_tok.line, out_tok.length,
                      out_tok.start, out_tok.value};
    assign m_tuser = {out_tok.err, out_tok.kind};
    assign m_tlast = out_tok.last;

endmodule

// File: design/asl_lexer_core.sv
module asl_lexer_core #(
    parameter int VALUE_BITS = 32,
    parameter int TAB_STOP   = 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_take,
    input  logic [7:0]      in_char,
    input  logic            in_eot,
    output asl_pkg::token_t tok0,
    output asl_pkg::token_t tok1,
    output logic [1:0]      tok_count
);

    localparam int PW = $clog2(TAB_STOP);
    localparam logic [PW-1:0] PH_LAST = PW'(TAB_STOP - 1);
    localparam logic [PW-1:0] PH_SAT  = PW'(65535 % TAB_STOP);

    asl_pkg::mode_t        mode_reg, mode_next;
    logic                  halted_reg, halted_next;
    logic [3:0]            open_kind_reg, open_kind_next;
    logic [VALUE_BITS-1:0] open_value_reg, open_value_next;
    logic [23:0]           open_start_reg, open_start_next;
    logic [15:0]           open_length_reg, open_length_next;
    logic [23:0]           open_line_reg, open_line_next;
    logic [15:0]           open_column_reg, open_column_next;
    logic [23:0]           char_index_reg, char_index_next;
    logic [23:0]           line_count_reg, line_count_next;
    logic [15:0]           column_count_reg, column_count_next;
    logic [PW-1:0]         phase_reg, phase_next;

    // Character classes
    logic is_dig, is_lo_hex, is_up_hex, is_alpha, is_alnum, is_xdig;
    logic is_sep, is_space, is_op, is_tab, is_nl;
    logic [3:0] digit;

    assign is_dig    = (in_char >= asl_pkg::CH_ZERO) && (in_char <= asl_pkg::CH_NINE);
    assign is_lo_hex = (in_char >= asl_pkg::CH_LO_A) && (in_char <= asl_pkg::CH_LO_F);
    assign is_up_hex = (in_char >= asl_pkg::CH_UP_A) && (in_char <= asl_pkg::CH_UP_F);
    assign is_alpha  = ((in_char >= asl_pkg::CH_LO_A) && (in_char <= asl_pkg::CH_LO_Z)) ||
                       ((in_char >= asl_pkg::CH_UP_A) && (in_char <= asl_pkg::CH_UP_Z));
    assign is_alnum  = is_dig || is_alpha;
    assign is_xdig   = is_dig || is_lo_hex || is_up_hex;
    assign is_sep    = (in_char == asl_pkg::CH_UNDER) || (in_char == asl_pkg::CH_QUOTE);
    assign is_tab    = (in_char == asl_pkg::CH_TAB);
    assign is_nl     = (in_char == asl_pkg::CH_NL);
    assign is_space  = (in_char == asl_pkg::CH_SPACE) || is_tab ||
                       (in_char == asl_pkg::CH_VT) || (in_char == asl_pkg::CH_FF) ||
                       (in_char == asl_pkg::CH_CR);
    assign is_op     = (in_char == asl_pkg::CH_STAR) || (in_char == asl_pkg::CH_PLUS) ||
                       (in_char == asl_pkg::CH_MINUS) || (in_char == asl_pkg::CH_SLASH) ||
                       (in_char == asl_pkg::CH_LESS) || (in_char == asl_pkg::CH_GREATER) ||
                       (in_char == asl_pkg::CH_CARET) || (in_char == asl_pkg::CH_TILDE);
    // letters a-f and A-F have low nibble 1..6
    assign digit     = is_dig ? in_char[3:0] : (in_char[3:0] + 4'd9);

    // Column of this character, tabs expanded through the tracked phase
    logic [16:0]   tab_sum;
    logic          tab_clamp;
    logic [15:0]   col, nextcol;
    logic [PW-1:0] col_phase, next_phase;

    assign tab_sum    = 17'(column_count_reg) - 17'(phase_reg) + 17'(TAB_STOP - 1);
    assign tab_clamp  = tab_sum > 17'(asl_pkg::MAX16);
    assign col        = !is_tab ? column_count_reg :
                        (tab_clamp ? asl_pkg::MAX16 : tab_sum[15:0]);
    assign col_phase  = !is_tab ? phase_reg : (tab_clamp ? PH_SAT : PH_LAST);
    assign nextcol    = (col == asl_pkg::MAX16) ? col : col + 16'd1;
    assign next_phase = (col == asl_pkg::MAX16) ? PH_SAT :
                        ((col_phase == PH_LAST) ? '0 : col_phase + PW'(1));

    // Saturating increments and number accumulate
    logic [23:0]           line_inc, index_inc;
    logic [15:0]           length_inc;
    logic [VALUE_BITS-1:0] acc_shift, acc_value;
    logic [63:0]           open_value_ext;
    logic                  digit_ok;
    logic [1:0]            num_err;

    assign line_inc   = (line_count_reg == asl_pkg::MAX24) ? line_count_reg
                                                           : line_count_reg + 24'd1;
    assign index_inc  = (char_index_reg == asl_pkg::MAX24) ? char_index_reg
                                                           : char_index_reg + 24'd1;
    assign length_inc = (open_length_reg == asl_pkg::MAX16) ? open_length_reg
                                                            : open_length_reg + 16'd1;
    assign open_value_ext = 64'(open_value_reg);

    always_comb begin
        case (mode_reg)
            asl_pkg::MODE_BIN: begin
                acc_shift = open_value_reg << 1;
                digit_ok  = (in_char == asl_pkg::CH_ZERO) || (in_char == asl_pkg::CH_ONE);
                num_err   = asl_pkg::ERR_BIN;
            end
            asl_pkg::MODE_DEC: begin
                acc_shift = (open_value_reg << 3) + (open_value_reg << 1);
                digit_ok  = is_dig;
                num_err   = asl_pkg::ERR_DEC;
            end
            default: begin
                acc_shift = open_value_reg << 4;
                digit_ok  = is_xdig;
                num_err   = asl_pkg::ERR_HEX;
            end
        endcase
    end

    assign acc_value = acc_shift + VALUE_BITS'(digit);

    // One lexer step per taken transaction
    logic            closed, reprocess, begin_emit;
    asl_pkg::token_t begin_tok;

    always_comb begin
        mode_next         = mode_reg;
        halted_next       = halted_reg;
        open_kind_next    = open_kind_reg;
        open_value_next   = open_value_reg;
        open_start_next   = open_start_reg;
        open_length_next  = open_length_reg;
        open_line_next    = open_line_reg;
        open_column_next  = open_column_reg;
        char_index_next   = char_index_reg;
        line_count_next   = line_count_reg;
        column_count_next = column_count_reg;
        phase_next        = phase_reg;
        tok0              = '0;
        tok1              = '0;
        tok_count         = 2'd0;
        closed            = 1'b0;
        reprocess         = 1'b0;
        begin_emit        = 1'b0;
        begin_tok         = '0;

        if (in_take && !halted_reg) begin
            if (in_eot) begin
                // trailing newline and end token, then halt
                tok0.kind   = asl_pkg::KIND_NEWLINE;
                tok0.start  = char_index_reg;
                tok0.line   = line_inc;
                tok1.kind   = asl_pkg::KIND_END;
                tok1.start  = char_index_reg;
                tok1.line   = line_inc;
                tok_count   = 2'd2;
                halted_next = 1'b1;
            end else begin
                char_index_next   = index_inc;
                column_count_next = nextcol;
                phase_next        = next_phase;

                case (mode_reg)
                    asl_pkg::MODE_COMMENT: begin
                        if (is_nl) begin
                            line_count_next   = line_inc;
                            column_count_next = '0;
                            phase_next        = '0;
                            mode_next         = asl_pkg::MODE_BEGIN;
                        end
                    end
                    asl_pkg::MODE_BIN, asl_pkg::MODE_DEC, asl_pkg::MODE_HEX: begin
                        if (is_alnum && !digit_ok) begin
                            tok0.kind   = asl_pkg::KIND_ERROR;
                            tok0.start  = char_index_reg;
                            tok0.length = 16'd1;
                            tok0.line   = line_count_reg;
                            tok0.column = col;
                            tok0.err    = num_err;
                            tok_count   = 2'd1;
                            halted_next = 1'b1;
                        end else if (is_sep) begin
                            open_length_next = length_inc;
                        end else if (is_xdig) begin
                            open_length_next = length_inc;
                            open_value_next  = acc_value;
                        end else begin
                            tok0.kind   = open_kind_reg;
                            tok0.value  = open_value_ext[31:0];
                            tok0.start  = open_start_reg;
                            tok0.length = open_length_reg;
                            tok0.line   = open_line_reg;
                            tok0.column = open_column_reg;
                            tok_count   = 2'd1;
                            closed      = 1'b1;
                            reprocess   = 1'b1;
                            mode_next   = asl_pkg::MODE_BEGIN;
                        end
                    end
                    asl_pkg::MODE_WORD: begin
                        if (is_alnum || (in_char == asl_pkg::CH_UNDER)) begin
                            open_length_next = length_inc;
                        end else begin
                            tok0.kind   = open_kind_reg;
                            tok0.start  = open_start_reg;
                            tok0.length = open_length_reg;
                            tok0.line   = open_line_reg;
                            tok0.column = open_column_reg;
                            tok_count   = 2'd1;
                            closed      = 1'b1;
                            reprocess   = 1'b1;
                            mode_next   = asl_pkg::MODE_BEGIN;
                        end
                    end
                    default: begin
                        reprocess = 1'b1;
                        mode_next = asl_pkg::MODE_BEGIN;
                    end
                endcase

                // start a new token with this character
                if (reprocess && !is_space) begin
                    open_start_next  = char_index_reg;
                    open_line_next   = line_count_reg;
                    open_column_next = col;
                    open_length_next = 16'd1;
                    open_value_next  = '0;
                    begin_tok.start  = char_index_reg;
                    begin_tok.length = 16'd1;
                    begin_tok.line   = line_count_reg;
                    begin_tok.column = col;
                    if (in_char == asl_pkg::CH_DOLLAR) begin
                        open_kind_next = asl_pkg::KIND_NUM;
                        mode_next      = asl_pkg::MODE_HEX;
                    end else if (in_char == asl_pkg::CH_PERCENT) begin
                        open_kind_next = asl_pkg::KIND_NUM;
                        mode_next      = asl_pkg::MODE_BIN;
                    end else if (is_dig) begin
                        open_kind_next  = asl_pkg::KIND_NUM;
                        mode_next       = asl_pkg::MODE_DEC;
                        open_value_next = VALUE_BITS'(digit);
                    end else if (is_op) begin
                        begin_emit      = 1'b1;
                        begin_tok.kind  = asl_pkg::KIND_OP;
                        begin_tok.value = 32'(in_char);
                    end else if (in_char == asl_pkg::CH_COLON) begin
                        begin_emit     = 1'b1;
                        begin_tok.kind = asl_pkg::KIND_COLON;
                    end else if (in_char == asl_pkg::CH_COMMA) begin
                        begin_emit     = 1'b1;
                        begin_tok.kind = asl_pkg::KIND_COMMA;
                    end else if (is_nl) begin
                        begin_emit        = 1'b1;
                        begin_tok.kind    = asl_pkg::KIND_NEWLINE;
                        line_count_next   = line_inc;
                        column_count_next = '0;
                        phase_next        = '0;
                    end else if (in_char == asl_pkg::CH_LPAREN) begin
                        begin_emit     = 1'b1;
                        begin_tok.kind = asl_pkg::KIND_OPEN;
                    end else if (in_char == asl_pkg::CH_RPAREN) begin
                        begin_emit     = 1'b1;
                        begin_tok.kind = asl_pkg::KIND_CLOSE;
                    end else if (in_char == asl_pkg::CH_SEMI) begin
                        begin_emit     = 1'b1;
                        begin_tok.kind = asl_pkg::KIND_NEWLINE;
                        mode_next      = asl_pkg::MODE_COMMENT;
                    end else if ((in_char == asl_pkg::CH_UNDER) || is_alpha) begin
                        open_kind_next = asl_pkg::KIND_WORD;
                        mode_next      = asl_pkg::MODE_WORD;
                    end else begin
                        begin_emit     = 1'b1;
                        begin_tok.kind = asl_pkg::KIND_ERROR;
                        begin_tok.err  = asl_pkg::ERR_UNKNOWN;
                        halted_next    = 1'b1;
                    end
                end

                // place the new token behind a closed one
                if (begin_emit) begin
                    if (closed) begin
                        tok1      = begin_tok;
                        tok_count = 2'd2;
                    end else begin
                        tok0      = begin_tok;
                        tok_count = 2'd1;
                    end
                end
            end
        end

        // mark the final token of this transaction
        case (tok_count)
            2'd1:    tok0.last = 1'b1;
            2'd2:    tok1.last = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= asl_pkg::MODE_BEGIN;
            halted_reg       <= 1'b0;
            open_kind_reg    <= '0;
            open_value_reg   <= '0;
            open_start_reg   <= '0;
            open_length_reg  <= '0;
            open_line_reg    <= '0;
            open_column_reg  <= '0;
            char_index_reg   <= '0;
            line_count_reg   <= 24'd1;
            column_count_reg <= '0;
            phase_reg        <= '0;
        end else begin
            mode_reg         <= mode_next;
            halted_reg       <= halted_next;
            open_kind_reg    <= open_kind_next;
            open_value_reg   <= open_value_next;
            open_start_reg   <= open_start_next;
            open_length_reg  <= open_length_next;
            open_line_reg    <= open_line_next;
            open_column_reg  <= open_column_next;
            char_index_reg   <= char_index_next;
            line_count_reg   <= line_count_next;
            column_count_reg <= column_count_next;
            phase_reg        <= phase_next;
        end
    end

    // A halted lexer stays silent until reset
    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> (tok_count == 2'd0))
        else $error("tokens produced while halted");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halt released without reset");

    a_eot_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_take && in_eot && !halted_reg) |->
        (tok_count == 2'd2 && tok1.kind == asl_pkg::KIND_END && tok1.last))
        else $error("end of text did not give newline and end tokens");

endmodule

// File: design/asl_token_fifo.sv
module asl_token_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [1:0]      wr_count,
    input  asl_pkg::token_t wr_tok0,
    input  asl_pkg::token_t wr_tok1,
    output logic            room,
    output logic            out_valid,
    input  logic            out_ready,
    output asl_pkg::token_t out_tok
);

    localparam int AW = $clog2(asl_pkg::FIFO_DEPTH);
    localparam int CW = AW + 1;

    asl_pkg::token_t mem [asl_pkg::FIFO_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            pop;

    assign out_valid = (count_reg != '0);
    assign out_tok   = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // space for a full pair of tokens after this cycle's read
    assign room      = (count_reg - CW'(pop)) <= CW'(asl_pkg::FIFO_DEPTH - 2);

    assign wr_ptr_next = wr_ptr_reg + AW'(wr_count);
    assign rd_ptr_next = rd_ptr_reg + AW'(pop);
    assign count_next  = count_reg + CW'(wr_count) - CW'(pop);

    // Store up to two tokens per cycle
    always_ff @(posedge aclk) begin
        if (wr_count != 2'd0) begin
            mem[wr_ptr_reg] <= wr_tok0;
        end
        if (wr_count == 2'd2) begin
            mem[wr_ptr_reg + AW'(1)] <= wr_tok1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ((CW + 1)'(count_reg) + (CW + 1)'(wr_count) - (CW + 1)'(pop))
        <= (CW + 1)'(asl_pkg::FIFO_DEPTH))
        else $error("token queue overflow");

endmodule
